/* rtl/core/bfba_pkg.sv */
// Shared types and constants of the best-fit block allocator.
// Used by every module of the allocator but bfba_ram; depends on nothing.
`timescale 1ns / 1ps

package bfba_pkg;

  // Table size and the width of one stored block size.
  localparam int unsigned BLOCK_COUNT = 16;
  localparam int unsigned SIZE_BITS   = 16;

  // Widths derived from the table size.
  localparam int unsigned IDX_W = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned CNT_W = $clog2(BLOCK_COUNT + 1);

  // Fixed widths of the interface fields.
  localparam int unsigned CFG_W = 5;

  // Codes carried in the mode field of a request.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // One request as it arrives on the input port.
  typedef struct packed {
    logic        mode;
    logic [3:0]  load_index;
    logic [15:0] size_value;
  } in_item_t;

  // One result as it leaves on the output port.
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_index;
    logic [15:0] chosen_size;
    logic [15:0] request_number;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // write one block and free it, emit an empty result
    logic scan_init;  // capture the required size and the search length
    logic scan_step;  // issue one table read and judge the previous one
    logic commit;     // mark the chosen block and emit the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;  // every block in the search has been judged
  } status_t;

endpackage

/* rtl/core/bfba_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the block sizes of the allocator.
`timescale 1ns / 1ps

module bfba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bfba_ctrl.sv */
// Controller of the best-fit block allocator: sequences load, scan and commit.
// Depends on bfba_pkg; drives the datapath bfba_dp through command signals.
`timescale 1ns / 1ps

module bfba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             mode_i,
  input  bfba_pkg::status_t status_i,
  output bfba_pkg::cmd_t   cmd_o,
  output logic             busy
);

  bfba_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfba_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      bfba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode_i == bfba_pkg::MODE_LOAD) begin
            // A load finishes in the cycle it is taken.
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = bfba_pkg::ST_SCAN;
          end
        end
      end
      bfba_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = bfba_pkg::ST_COMMIT;
        end
      end
      bfba_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = bfba_pkg::ST_IDLE;
      end
      default: begin
        state_d = bfba_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/bfba_dp.sv */
// Datapath of the best-fit block allocator: size table, allocated marks,
// running best candidate and result register. Depends on bfba_pkg, bfba_ram.
`timescale 1ns / 1ps

module bfba_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfba_pkg::CFG_W-1:0] cfg_wdata_i,
  input  bfba_pkg::in_item_t         req_i,
  input  bfba_pkg::cmd_t             cmd_i,
  output bfba_pkg::status_t          status_o,
  output logic                       result_valid_o,
  output bfba_pkg::out_item_t        res_o
);

  localparam int unsigned IW = bfba_pkg::IDX_W;
  localparam int unsigned CW = bfba_pkg::CNT_W;
  localparam int unsigned SW = bfba_pkg::SIZE_BITS;
  localparam int unsigned BC = bfba_pkg::BLOCK_COUNT;

  // Configuration and allocation state.
  logic [bfba_pkg::CFG_W-1:0] blocks_in_use_q;
  logic [BC-1:0]              taken_q, taken_d;
  logic [15:0]                req_cnt_q, req_cnt_d;

  // Scan state.
  logic [SW-1:0] need_q, need_d;
  logic [CW-1:0] limit_q, limit_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;
  logic          cmp_vld_q, cmp_vld_d;
  logic [IW-1:0] cmp_idx_q, cmp_idx_d;
  logic          found_q, found_d;
  logic [IW-1:0] best_idx_q, best_idx_d;
  logic [SW-1:0] best_size_q, best_size_d;

  // Result register.
  logic                result_valid_q, result_valid_d;
  bfba_pkg::out_item_t res_q, res_d;

  // Table interface.
  logic          load_in_range;
  logic          ram_we;
  logic [SW-1:0] ram_rdata;
  logic          issue;
  logic          is_better;

  assign load_in_range = (32'(req_i.load_index) < BC);
  assign ram_we        = cmd_i.load && load_in_range;

  bfba_ram #(
    .WIDTH (SW),
    .DEPTH (BC)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (IW'(req_i.load_index)),
    .wdata_i (SW'(req_i.size_value)),
    .raddr_i (rd_cnt_q[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // A read is issued while blocks remain; the scan ends once the last read is judged.
  assign issue              = cmd_i.scan_step && (rd_cnt_q < limit_q);
  assign status_o.scan_done = (rd_cnt_q >= limit_q) && !cmp_vld_q;

  // The block just read beats the best so far only when strictly smaller.
  assign is_better = cmp_vld_q && !taken_q[cmp_idx_q] && (ram_rdata >= need_q) &&
                     (!found_q || (ram_rdata < best_size_q));

  // Scan, commit and result logic.
  always_comb begin
    taken_d        = taken_q;
    req_cnt_d      = req_cnt_q;
    need_d         = need_q;
    limit_d        = limit_q;
    rd_cnt_d       = rd_cnt_q;
    cmp_vld_d      = 1'b0;
    cmp_idx_d      = cmp_idx_q;
    found_d        = found_q;
    best_idx_d     = best_idx_q;
    best_size_d    = best_size_q;
    result_valid_d = 1'b0;
    res_d          = res_q;

    if (cmd_i.load) begin
      if (load_in_range) begin
        taken_d[IW'(req_i.load_index)] = 1'b0;
      end
      result_valid_d = 1'b1;
      res_d          = '0;
    end

    if (cmd_i.scan_init) begin
      need_d   = SW'(req_i.size_value);
      limit_d  = (32'(blocks_in_use_q) > BC) ? CW'(BC) : CW'(blocks_in_use_q);
      rd_cnt_d = '0;
      found_d  = 1'b0;
    end

    if (issue) begin
      cmp_vld_d = 1'b1;
      cmp_idx_d = rd_cnt_q[IW-1:0];
      rd_cnt_d  = rd_cnt_q + 1'b1;
    end

    if (is_better) begin
      found_d     = 1'b1;
      best_idx_d  = cmp_idx_q;
      best_size_d = ram_rdata;
    end

    if (cmd_i.commit) begin
      result_valid_d       = 1'b1;
      res_d                = '0;
      res_d.request_number = req_cnt_q;
      req_cnt_d            = req_cnt_q + 16'd1;
      if (found_q) begin
        taken_d[best_idx_q] = 1'b1;
        res_d.granted       = 1'b1;
        res_d.chosen_index  = 4'(best_idx_q);
        res_d.chosen_size   = 16'(best_size_q);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_in_use_q <= '0;
      taken_q         <= '0;
      req_cnt_q       <= '0;
      cmp_vld_q       <= 1'b0;
      result_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blocks_in_use_q <= cfg_wdata_i;
      end
      taken_q        <= taken_d;
      req_cnt_q      <= req_cnt_d;
      cmp_vld_q      <= cmp_vld_d;
      result_valid_q <= result_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    need_q      <= need_d;
    limit_q     <= limit_d;
    rd_cnt_q    <= rd_cnt_d;
    cmp_idx_q   <= cmp_idx_d;
    found_q     <= found_d;
    best_idx_q  <= best_idx_d;
    best_size_q <= best_size_d;
    res_q       <= res_d;
  end

  assign result_valid_o = result_valid_q;
  assign res_o          = res_q;

endmodule

/* rtl/core/best_fit_block_allocator.sv */
// Best-fit block allocator: a load request sets one block's size and frees it;
// an allocation request takes the smallest free block that fits, lowest index
// on a tie. A request is taken when start is high and busy is low. Every
// request gives exactly one result, shown for one cycle with result_valid_o;
// the receiver cannot stall it, so it must sample on that cycle. A load's
// result appears in the cycle after it is taken and busy stays low. An
// allocation request keeps busy high while the size table is read one block
// per cycle through its single registered read port, while the last read is
// judged, while the scan is seen to have ended and while the result is
// committed. The search length is blocks_in_use capped at sixteen; when it
// is zero, no read is made. The result appears as busy falls.
// Depends on bfba_pkg, bfba_ctrl, bfba_dp and bfba_ram.
`timescale 1ns / 1ps

module best_fit_block_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfba_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       start,
  output logic                       busy,
  input  bfba_pkg::in_item_t         req_i,
  output logic                       result_valid_o,
  output bfba_pkg::out_item_t        res_o
);

  bfba_pkg::cmd_t    cmd;
  bfba_pkg::status_t status;

  // Sequencer.
  bfba_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .mode_i   (req_i.mode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Table, search and result datapath.
  bfba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_i          (req_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

endmodule
